>>> rtl/core/abt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package abt_pkg;

  localparam int unsigned OP_W       = 2;
  localparam int unsigned KEY_W      = 16;
  localparam int unsigned DRV_W      = 4;
  localparam int unsigned ENTRY_CNT_W = 5;

  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_BIND   = 2'd1;
  localparam logic [OP_W-1:0] OP_UNBIND = 2'd2;

  // number of driver slots a bind may name
  localparam int unsigned DRIVER_SLOTS = 16;
  localparam int unsigned DRV_LIM_W    = 9;
  localparam logic [DRV_LIM_W-1:0] DRV_LIMIT = DRV_LIM_W'(DRIVER_SLOTS);

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [DRV_W-1:0] drv;
  } abt_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_ACT,
    ST_RD_LAST,
    ST_WR_MOVE,
    ST_DONE
  } abt_state_e;

endpackage

`default_nettype wire

>>> rtl/core/abt_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface abt_req_if import abt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  op;
  logic [KEY_W-1:0] node_addr;
  logic [DRV_W-1:0] driver_id;

  modport source (output valid, output op, output node_addr, output driver_id,
                  input ready);
  modport sink   (input valid, input op, input node_addr, input driver_id,
                  output ready);
endinterface

interface abt_rsp_if import abt_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   status;
  logic                   found;
  logic [DRV_W-1:0]       bound_driver;
  logic [ENTRY_CNT_W-1:0] entry_count;

  modport source (output valid, output status, output found, output bound_driver,
                  output entry_count, input ready);
  modport sink   (input valid, input status, input found, input bound_driver,
                  input entry_count, output ready);
endinterface

`default_nettype wire

>>> rtl/core/abt_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module abt_mem import abt_pkg::*; #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned ADDR_W = 4
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire abt_entry_t        wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output abt_entry_t             rdata_o
);

  abt_entry_t mem_q [DEPTH];
  abt_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/core/address_binding_table.sv
`timescale 1ns / 1ps
`default_nettype none

// channel  dir  payload                                          beat taken when
// req_i    in   op, node_addr, driver_id                         valid && ready
// rsp_o    out  status, found, bound_driver, entry_count         valid && ready
//
// one operation at a time; the key compare is shared across the entries in turn
// a search reads, then compares, each entry (up to the entry count); then the action
// a moved unbind adds read-last and write-move; memory has one registered read port
// reset clears state, entry count, output valid; entries are never read before written
// a finished beat waits in the output register; the next request is taken meanwhile

module address_binding_table import abt_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  abt_req_if.sink   req_i,
  abt_rsp_if.source rsp_o
);

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(TABLE_DEPTH);

  abt_state_e state_q, state_d;

  logic [OP_W-1:0]  op_q, op_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic [DRV_W-1:0] drv_q, drv_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [IDX_W-1:0] slot_q, slot_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             hit_q, hit_d;
  logic             status_q, status_d;
  logic [DRV_W-1:0] bound_q, bound_d;

  logic                   rsp_valid_q, rsp_valid_d;
  logic                   rsp_status_q;
  logic                   rsp_found_q;
  logic [DRV_W-1:0]       rsp_bound_q;
  logic [ENTRY_CNT_W-1:0] rsp_count_q;
  logic                   rsp_load;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  abt_entry_t       mem_wdata;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;
  abt_entry_t       mem_rdata;

  logic [CNT_W-1:0] last_cnt;
  logic [IDX_W-1:0] last_idx;
  logic             drv_ok;
  logic             is_lookup;

  abt_mem #(
    .DEPTH (TABLE_DEPTH),
    .ADDR_W(IDX_W)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign last_cnt  = cnt_q - CNT_W'(1);
  assign last_idx  = last_cnt[IDX_W-1:0];
  assign drv_ok    = (DRV_LIM_W'(drv_q) < DRV_LIMIT);
  assign is_lookup = (op_q != OP_BIND) && (op_q != OP_UNBIND);
  assign req_i.ready = (state_q == ST_IDLE);

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    key_d     = key_q;
    drv_d     = drv_q;
    idx_d     = idx_q;
    slot_d    = slot_q;
    cnt_d     = cnt_q;
    hit_d     = hit_q;
    status_d  = status_q;
    bound_d   = bound_q;
    mem_we    = 1'b0;
    mem_waddr = slot_q;
    mem_wdata = '{key: key_q, drv: drv_q};
    mem_re    = 1'b0;
    mem_raddr = idx_q;
    rsp_load  = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          op_d     = req_i.op;
          key_d    = req_i.node_addr;
          drv_d    = req_i.driver_id;
          idx_d    = '0;
          hit_d    = 1'b0;
          status_d = STATUS_OK;
          bound_d  = '0;
          state_d  = (cnt_q == '0) ? ST_ACT : ST_READ;
        end
      end
      ST_READ: begin
        mem_re  = 1'b1;
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (mem_rdata.key == key_q) begin
          hit_d   = 1'b1;
          slot_d  = idx_q;
          if (is_lookup) begin
            bound_d = mem_rdata.drv;
          end
          state_d = ST_ACT;
        end else if (CNT_W'(idx_q) == last_cnt) begin
          state_d = ST_ACT;
        end else begin
          idx_d   = idx_q + IDX_W'(1);
          state_d = ST_READ;
        end
      end
      ST_ACT: begin
        state_d = ST_DONE;
        if (op_q == OP_BIND) begin
          if (!drv_ok) begin
            status_d = STATUS_FULL;
          end else if (hit_q) begin
            mem_we = 1'b1;
          end else if (cnt_q == CNT_MAX) begin
            status_d = STATUS_FULL;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = cnt_q[IDX_W-1:0];
            cnt_d     = cnt_q + CNT_W'(1);
          end
        end else if (op_q == OP_UNBIND) begin
          if (hit_q) begin
            if (CNT_W'(slot_q) < last_cnt) begin
              state_d = ST_RD_LAST;
            end else begin
              cnt_d = last_cnt;
            end
          end
        end
      end
      ST_RD_LAST: begin
        mem_re    = 1'b1;
        mem_raddr = last_idx;
        state_d   = ST_WR_MOVE;
      end
      ST_WR_MOVE: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata;
        cnt_d     = last_cnt;
        state_d   = ST_DONE;
      end
      ST_DONE: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
    if (rsp_load) begin
      rsp_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    key_q    <= key_d;
    drv_q    <= drv_d;
    idx_q    <= idx_d;
    slot_q   <= slot_d;
    hit_q    <= hit_d;
    status_q <= status_d;
    bound_q  <= bound_d;
    if (rsp_load) begin
      rsp_status_q <= status_q;
      rsp_found_q  <= hit_q;
      rsp_bound_q  <= bound_q;
      rsp_count_q  <= ENTRY_CNT_W'(cnt_q);
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.status       = rsp_status_q;
  assign rsp_o.found        = rsp_found_q;
  assign rsp_o.bound_driver = rsp_bound_q;
  assign rsp_o.entry_count  = rsp_count_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_MAX)
    else $error("entry count above table depth");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !mem_we)
    else $error("table written while idle");

  a_cmp_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CMP) |-> (CNT_W'(idx_q) < cnt_q))
    else $error("search index past entry count");

  a_cnt_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(cnt_q) |-> ($past(state_q) == ST_ACT || $past(state_q) == ST_WR_MOVE))
    else $error("entry count changed outside an action step");

  a_load_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_load |=> (rsp_valid_q && state_q == ST_IDLE))
    else $error("result beat not presented after completion");

endmodule

`default_nettype wire
